@@ design/srsw_pkg.sv @@
// shared types, codes and constants of the selective-repeat sender window
package srsw_pkg;

  localparam int SEQ_W        = 16;
  localparam int SACK_W       = 31;
  localparam int WSIZE_W      = 6;
  localparam int TOTAL_W      = 16;
  localparam int KIND_W       = 2;
  localparam int STAT_W       = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int MAX_WINDOW_DEF = 32;
  localparam int JOB_DEPTH    = 2;

  localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [STAT_W-1:0] STAT_RUN  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DONE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FAIL = 2'd2;

  localparam logic [1:0] TIMEOUT_LIMIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CHUNKS = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [SACK_W-1:0] sack_bits;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  send_seq;
    logic              send_valid;
    logic              is_resend;
    logic [STAT_W-1:0] status;
    logic              last;
  } out_item_t;

  // fixed part of a job handed from the front to the back
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              resend;
    logic [STAT_W-1:0] status;
  } job_hdr_t;

endpackage

@@ design/selective_repeat_sender_window.sv @@
// a result reaches the out side through the job queue, the back end's job registers and the output
// register, and is held back further by every acknowledged slot skipped before it on a resend
// events go into a two-deep job queue at one event per cycle while in_full is low; the back end
// loads a job and then walks the window slots in order up to the last one sent
// (at most MAX_WINDOW), or emits one empty result, and takes the next job only when done
// reset: synchronous active-low rst_n clears the window, queue and output register
module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_item_t              in_item,
  input  logic                  out_pop,
  output logic                  out_empty,
  output out_item_t             out_item
);

  localparam int JOB_W = $bits(job_hdr_t) + MAX_WINDOW;

  logic                  job_push, job_full, job_pop, job_empty;
  job_hdr_t              push_hdr, pop_hdr;
  logic [MAX_WINDOW-1:0] push_pend, pop_pend;
  logic [JOB_W-1:0]      pop_word;

  assign in_full = job_full;

  srsw_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_item   (in_item),
    .job_full  (job_full),
    .job_push  (job_push),
    .job_hdr   (push_hdr),
    .job_pend  (push_pend)
  );

  srsw_job_fifo #(.W(JOB_W), .DEPTH(JOB_DEPTH)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({push_hdr, push_pend}),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (pop_word),
    .empty (job_empty)
  );

  assign pop_hdr  = pop_word[JOB_W-1 -: $bits(job_hdr_t)];
  assign pop_pend = pop_word[MAX_WINDOW-1:0];

  srsw_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_hdr   (pop_hdr),
    .job_pend  (pop_pend),
    .job_pop   (job_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

@@ design/srsw_job_fifo.sv @@
// small register queue carrying jobs from the front to the back
module srsw_job_fifo
  import srsw_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ design/srsw_front.sv @@
// front end: window state, event classification and job building
module srsw_front
  import srsw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_push,
  input  in_item_t              in_item,
  input  logic                  job_full,
  output logic                  job_push,
  output job_hdr_t              job_hdr,
  output logic [MAX_WINDOW-1:0] job_pend
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int SX_W  = (MAX_WINDOW > SACK_W + 1) ? MAX_WINDOW : SACK_W + 1;
  localparam int CW    = SEQ_W + 1;

  logic [WSIZE_W-1:0]    win_r;
  logic [TOTAL_W-1:0]    tot_r;
  logic [SEQ_W-1:0]      base_r, base_nxt;
  logic [SEQ_W-1:0]      next_r, next_nxt;
  logic [1:0]            trun_r, trun_nxt;
  logic [MAX_WINDOW-1:0] map_r, map_nxt;
  logic [STAT_W-1:0]     fin_r, fin_nxt;

  logic [WIN_W-1:0]      win_eff;
  logic [TOTAL_W-1:0]    tot_eff;
  logic [SEQ_W-1:0]      ack_d;
  logic [SEQ_W-1:0]      avail;
  logic [SEQ_W-1:0]      span;
  logic [SX_W-1:0]       sack_sh;
  logic                  do_send;
  logic [SEQ_W-1:0]      send_base;
  logic [CW-1:0]         limit, bound, cnt;

  assign job_push = in_push && !job_full;

  always_comb begin
    if (win_r == '0) begin
      win_eff = WIN_W'(1);
    end else if ((WIN_W + 1)'(win_r) > (WIN_W + 1)'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(win_r);
    end
    tot_eff = (tot_r == '0) ? TOTAL_W'(1) : tot_r;
  end

  always_comb begin
    base_nxt  = base_r;
    next_nxt  = next_r;
    trun_nxt  = trun_r;
    map_nxt   = map_r;
    fin_nxt   = fin_r;
    do_send   = 1'b0;
    send_base = base_r;
    job_pend  = '0;
    job_hdr   = '0;
    ack_d     = in_item.ack_seq - base_r;
    avail     = (tot_eff > in_item.ack_seq) ? tot_eff - in_item.ack_seq : '0;
    span      = next_r - base_r;
    sack_sh   = SX_W'({in_item.sack_bits, 1'b0});
    limit     = '0;
    bound     = '0;
    cnt       = '0;

    if (fin_r == STAT_RUN) begin
      case (in_item.kind)
        KIND_START: begin
          do_send = 1'b1;
        end
        KIND_ACK: begin
          // acks below the base or beyond what was sent are dropped
          if (in_item.ack_seq >= base_r && in_item.ack_seq <= next_r) begin
            map_nxt = map_r >> ack_d;
            for (int j = 1; j < MAX_WINDOW; j++) begin
              if (sack_sh[j] && (WIN_W + 1)'(j) < (WIN_W + 1)'(win_eff) &&
                  CW'(j) < CW'(avail)) begin
                map_nxt[j] = 1'b1;
              end
            end
            base_nxt = in_item.ack_seq;
            trun_nxt = 2'd0;
            if (in_item.ack_seq >= tot_eff) begin
              fin_nxt = STAT_DONE;
            end else begin
              do_send   = 1'b1;
              send_base = in_item.ack_seq;
            end
          end
        end
        KIND_TIMEOUT: begin
          trun_nxt = trun_r + 2'd1;
          if (trun_nxt == TIMEOUT_LIMIT) begin
            fin_nxt = STAT_FAIL;
          end else begin
            job_hdr.seq    = base_r;
            job_hdr.resend = 1'b1;
            for (int j = 0; j < MAX_WINDOW; j++) begin
              job_pend[j] = !map_r[j] && (CW'(j) < CW'(span));
            end
          end
        end
        default: begin
        end
      endcase
    end

    // new sends fill the window up to the transfer end
    if (do_send) begin
      limit = CW'(send_base) + CW'(win_eff);
      bound = (limit < CW'(tot_eff)) ? limit : CW'(tot_eff);
      cnt   = (bound > CW'(next_r)) ? bound - CW'(next_r) : '0;
      job_hdr.seq = next_r;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        job_pend[j] = CW'(j) < cnt;
      end
      next_nxt = next_r + cnt[SEQ_W-1:0];
    end

    job_hdr.status = fin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WSIZE_W'(1);
      tot_r  <= TOTAL_W'(1);
      base_r <= '0;
      next_r <= '0;
      trun_r <= '0;
      map_r  <= '0;
      fin_r  <= STAT_RUN;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_WINDOW_SIZE:  win_r <= cfg_wdata[WSIZE_W-1:0];
          CFG_TOTAL_CHUNKS: tot_r <= cfg_wdata[TOTAL_W-1:0];
          default: begin
          end
        endcase
      end
      if (job_push) begin
        base_r <= base_nxt;
        next_r <= next_nxt;
        trun_r <= trun_nxt;
        map_r  <= map_nxt;
        fin_r  <= fin_nxt;
      end
    end
  end

  // a finished transfer never leaves its final status
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r != STAT_RUN |=> fin_r == $past(fin_r))
    else $error("finish status changed after completion or failure");

  // in-flight span never exceeds the largest window
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    (next_r >= base_r) && ((next_r - base_r) <= SEQ_W'(MAX_WINDOW)))
    else $error("in-flight span out of range");

  a_trun: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r == STAT_RUN |-> trun_r != TIMEOUT_LIMIT)
    else $error("timeout run reached the limit while still running");

endmodule

@@ design/srsw_back.sv @@
// back end: walks a job's slot bitmap and emits one result per pending chunk, or one empty result
module srsw_back
  import srsw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_empty,
  input  job_hdr_t              job_hdr,
  input  logic [MAX_WINDOW-1:0] job_pend,
  output logic                  job_pop,
  input  logic                  out_pop,
  output logic                  out_empty,
  output out_item_t             out_item
);

  logic                  act_r, act_nxt;
  logic                  blank_r, blank_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic [MAX_WINDOW-1:0] pend_r, pend_nxt;
  logic                  resend_r, resend_nxt;
  logic [STAT_W-1:0]     stat_r, stat_nxt;
  logic                  oval_r, oval_nxt;
  out_item_t             oitem_r, oitem_nxt;
  logic                  slot_free;
  logic                  emit;
  out_item_t             item;
  logic                  tail_clear;

  assign slot_free  = !oval_r || out_pop;
  assign job_pop    = !act_r && !job_empty;
  assign out_empty  = !oval_r;
  assign out_item   = oitem_r;
  assign tail_clear = (pend_r >> 1) == '0;

  always_comb begin
    act_nxt    = act_r;
    blank_nxt  = blank_r;
    seq_nxt    = seq_r;
    pend_nxt   = pend_r;
    resend_nxt = resend_r;
    stat_nxt   = stat_r;
    emit       = 1'b0;
    item       = '0;
    item.status = stat_r;

    if (!act_r) begin
      if (!job_empty) begin
        act_nxt    = 1'b1;
        blank_nxt  = (job_pend == '0);
        seq_nxt    = job_hdr.seq;
        pend_nxt   = job_pend;
        resend_nxt = job_hdr.resend;
        stat_nxt   = job_hdr.status;
      end
    end else if (blank_r) begin
      // nothing to send: one empty result closes the transaction
      if (slot_free) begin
        emit      = 1'b1;
        item.last = 1'b1;
        act_nxt   = 1'b0;
      end
    end else if (pend_r[0]) begin
      if (slot_free) begin
        emit            = 1'b1;
        item.send_seq   = seq_r;
        item.send_valid = 1'b1;
        item.is_resend  = resend_r;
        item.last       = tail_clear;
        pend_nxt        = pend_r >> 1;
        seq_nxt         = seq_r + 1'b1;
        act_nxt         = !tail_clear;
      end
    end else begin
      // acknowledged slot, skip
      pend_nxt = pend_r >> 1;
      seq_nxt  = seq_r + 1'b1;
    end

    oval_nxt  = emit ? 1'b1 : (out_pop ? 1'b0 : oval_r);
    oitem_nxt = emit ? item : oitem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_r  <= blank_nxt;
    seq_r    <= seq_nxt;
    pend_r   <= pend_nxt;
    resend_r <= resend_nxt;
    stat_r   <= stat_nxt;
    oitem_r  <= oitem_nxt;
  end

  // a result that is not the last leaves its job running
  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    emit && !item.last |=> act_r)
    else $error("job ended before its last result");

  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && !oitem_r.send_valid |-> oitem_r.send_seq == '0 && oitem_r.last)
    else $error("empty result carries a sequence number or is not last");

  // a waiting result stays put until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    oval_r && !out_pop |=> oval_r && $stable(oitem_r))
    else $error("waiting result changed before it was taken");

endmodule
